// File: rtl/lop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lop_pkg
// Shared types and codes of the linear ordering evaluator.
// ----------------------------------------------------------------------------
package lop_pkg;

    localparam int CELL_W = 32;
    localparam int ACC_W  = 44;
    localparam int IDX_W  = 6;
    localparam int FUNC_W = 3;
    localparam int SIZE_W = 7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FN_LOAD_CELL = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_PERM = 3'd1;
    localparam logic [FUNC_W-1:0] FN_EVAL      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_NORM      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_BOUNDS    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [CELL_W-1:0] cell_value;
        logic [IDX_W-1:0]         perm_position;
        logic [IDX_W-1:0]         perm_item;
        logic signed [CELL_W-1:0] opt_value;
    } in_item_t;

    typedef struct packed {
        logic [FUNC_W-1:0]       done_func;
        logic signed [ACC_W-1:0] result_value;
        logic signed [ACC_W-1:0] upper_value;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EV_ROW,
        ST_EV_ROWW,
        ST_EV_SCAN,
        ST_EV_DRAIN,
        ST_NM_DIAG,
        ST_PR_A,
        ST_PR_B,
        ST_PR_FA,
        ST_PR_FB,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/lop_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lop_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/lop_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lop_alu
// Pair unit: one subtractor gives min, max and both reduced cell values.
// ----------------------------------------------------------------------------
module lop_alu (
    input  wire logic signed [lop_pkg::CELL_W-1:0] a,
    input  wire logic signed [lop_pkg::CELL_W-1:0] b,
    output logic signed [lop_pkg::CELL_W-1:0]      min_val,
    output logic signed [lop_pkg::CELL_W-1:0]      max_val,
    output logic signed [lop_pkg::CELL_W-1:0]      a_new,
    output logic signed [lop_pkg::CELL_W-1:0]      b_new
);
    import lop_pkg::*;

    logic signed [CELL_W:0]   diff;
    logic [CELL_W:0]          mag;
    logic                     lt;
    logic signed [CELL_W-1:0] sat;

    always_comb
    begin
        diff = {a[CELL_W-1], a} - {b[CELL_W-1], b};
        lt   = diff[CELL_W];
        mag  = lt ? (~diff + 1'b1) : diff;
        // magnitude tops out at 2^32-1, clamp to the positive limit
        if (mag[CELL_W:CELL_W-1] != 2'b00)
        begin
            sat = {1'b0, {(CELL_W-1){1'b1}}};
        end
        else
        begin
            sat = mag[CELL_W-1:0];
        end
        min_val = lt ? a : b;
        max_val = lt ? b : a;
        a_new   = lt ? '0 : sat;
        b_new   = lt ? sat : '0;
    end

endmodule
`default_nettype wire

// File: rtl/lop_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lop_core
// Sequencer, matrix and permutation stores, accumulators.
// ----------------------------------------------------------------------------
module lop_core #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_accept,
    input  wire lop_pkg::in_item_t                  in_item,
    input  wire logic [$clog2(MAX_ITEMS+1)-1:0]     n_use,
    input  wire logic                               out_free,
    output lop_pkg::core_stat_t                     stat,
    output lop_pkg::out_item_t                      res
);
    import lop_pkg::*;

    localparam int IW     = $clog2(MAX_ITEMS);
    localparam int CW     = $clog2(MAX_ITEMS + 1);
    localparam int MAW    = 2 * IW;
    localparam int MDEPTH = 1 << MAW;

    state_t state_reg, state_next;
    logic [FUNC_W-1:0]        func_reg, func_next;
    logic signed [CELL_W-1:0] opt_reg, opt_next;
    logic [IW-1:0]            i_reg, i_next;
    logic [IW-1:0]            j_reg, j_next;
    logic [IDX_W-1:0]         pi_reg, pi_next;
    logic                     pi_ok_reg, pi_ok_next;
    logic                     f1_reg, f1_next;
    logic                     f2_reg, f2_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  acc2_reg, acc2_next;
    logic signed [CELL_W-1:0] a_reg, a_next;
    logic signed [CELL_W-1:0] bnew_reg, bnew_next;
    logic                     pend_reg, pend_next;
    logic [IW-1:0]            pv_i_reg, pv_i_next;
    logic [IW-1:0]            pv_j_reg, pv_j_next;

    logic                     mat_we;
    logic [MAW-1:0]           mat_waddr;
    logic signed [CELL_W-1:0] mat_wdata;
    logic [MAW-1:0]           mat_raddr;
    logic signed [CELL_W-1:0] mat_rdata;
    logic                     perm_we;
    logic [IW-1:0]            perm_waddr;
    logic [IDX_W-1:0]         perm_wdata;
    logic [IW-1:0]            perm_raddr;
    logic [IDX_W-1:0]         perm_rdata;

    logic signed [CELL_W-1:0] alu_min, alu_max, alu_a_new, alu_b_new;
    logic [CW-1:0]            n_m1;
    logic                     lt2;
    logic                     j_last;
    logic                     pair_last;
    logic                     pj_ok;
    logic signed [ACC_W-1:0]  opt_ext;
    logic                     done;

    lop_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MDEPTH)
    ) u_mat (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    lop_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ITEMS)
    ) u_perm (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    lop_alu u_alu (
        .a       (a_reg),
        .b       (mat_rdata),
        .min_val (alu_min),
        .max_val (alu_max),
        .a_new   (alu_a_new),
        .b_new   (alu_b_new)
    );

    assign n_m1      = n_use - CW'(1);
    assign lt2       = n_use < CW'(2);
    assign j_last    = (CW'(j_reg) == n_m1);
    assign pair_last = j_last && (j_reg == i_reg + IW'(1));
    assign pj_ok     = 32'(perm_rdata) < 32'(MAX_ITEMS);
    assign opt_ext   = {{(ACC_W-CELL_W){opt_reg[CELL_W-1]}}, opt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            f1_reg    <= f1_next;
            f2_reg    <= f2_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        opt_reg   <= opt_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pi_reg    <= pi_next;
        pi_ok_reg <= pi_ok_next;
        acc_reg   <= acc_next;
        acc2_reg  <= acc2_next;
        a_reg     <= a_next;
        bnew_reg  <= bnew_next;
        pv_i_reg  <= pv_i_next;
        pv_j_reg  <= pv_j_next;
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        opt_next   = opt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pi_next    = pi_reg;
        pi_ok_next = pi_ok_reg;
        f1_next    = 1'b0;
        f2_next    = f1_reg && pi_ok_reg && pj_ok;
        acc_next   = acc_reg;
        acc2_next  = acc2_reg;
        a_next     = a_reg;
        bnew_next  = bnew_reg;
        pend_next  = pend_reg;
        pv_i_next  = pv_i_reg;
        pv_j_next  = pv_j_reg;
        done       = 1'b0;

        mat_raddr  = {IW'(pi_reg), IW'(perm_rdata)};
        perm_raddr = i_reg;
        mat_we     = 1'b0;
        mat_waddr  = {pv_i_reg, pv_j_reg};
        mat_wdata  = alu_a_new;
        perm_we    = 1'b0;
        perm_waddr = IW'(in_item.perm_position);
        perm_wdata = in_item.perm_item;

        res.done_func    = func_reg;
        res.result_value = acc_reg;
        res.upper_value  = '0;

        // evaluate pipeline: perm read reg, then matrix read reg; valid cells accumulate
        if (f2_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-CELL_W){mat_rdata[CELL_W-1]}}, mat_rdata};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_item.func)
                        FN_LOAD_CELL:
                        begin
                            if ((32'(in_item.row_index) < 32'(MAX_ITEMS)) &&
                                (32'(in_item.col_index) < 32'(MAX_ITEMS)))
                            begin
                                mat_we    = 1'b1;
                                mat_waddr = {IW'(in_item.row_index), IW'(in_item.col_index)};
                                mat_wdata = in_item.cell_value;
                            end
                        end
                        FN_LOAD_PERM:
                        begin
                            perm_we = 32'(in_item.perm_position) < 32'(MAX_ITEMS);
                        end
                        FN_EVAL:
                        begin
                            func_next  = FN_EVAL;
                            acc_next   = '0;
                            acc2_next  = '0;
                            i_next     = '0;
                            state_next = lt2 ? ST_DONE : ST_EV_ROW;
                        end
                        FN_NORM:
                        begin
                            func_next  = FN_NORM;
                            opt_next   = in_item.opt_value;
                            acc_next   = '0;
                            acc2_next  = '0;
                            i_next     = '0;
                            state_next = (n_use == '0) ? ST_DONE : ST_NM_DIAG;
                        end
                        FN_BOUNDS:
                        begin
                            func_next  = FN_BOUNDS;
                            acc_next   = '0;
                            acc2_next  = '0;
                            i_next     = '0;
                            j_next     = IW'(1);
                            pend_next  = 1'b0;
                            state_next = lt2 ? ST_DONE : ST_PR_A;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_EV_ROW:
            begin
                perm_raddr = i_reg;
                state_next = ST_EV_ROWW;
            end

            ST_EV_ROWW:
            begin
                pi_next    = perm_rdata;
                pi_ok_next = pj_ok;
                j_next     = i_reg + IW'(1);
                state_next = ST_EV_SCAN;
            end

            ST_EV_SCAN:
            begin
                perm_raddr = j_reg;
                f1_next    = 1'b1;
                if (pair_last)
                begin
                    state_next = ST_EV_DRAIN;
                end
                else if (j_last)
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_EV_ROW;
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end

            ST_EV_DRAIN:
            begin
                if (!f1_reg && !f2_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_NM_DIAG:
            begin
                mat_we    = 1'b1;
                mat_waddr = {i_reg, i_reg};
                mat_wdata = '0;
                if (CW'(i_reg) == n_m1)
                begin
                    i_next     = '0;
                    j_next     = IW'(1);
                    pend_next  = 1'b0;
                    state_next = lt2 ? ST_DONE : ST_PR_A;
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                end
            end

            ST_PR_A, ST_PR_FA:
            begin
                mat_raddr = {i_reg, j_reg};
                if (pend_reg)
                begin
                    acc_next = acc_reg + {{(ACC_W-CELL_W){alu_min[CELL_W-1]}}, alu_min};
                    if (func_reg == FN_BOUNDS)
                    begin
                        acc2_next = acc2_reg + {{(ACC_W-CELL_W){alu_max[CELL_W-1]}}, alu_max};
                    end
                    bnew_next = alu_b_new;
                    if (func_reg == FN_NORM)
                    begin
                        mat_we    = 1'b1;
                        mat_waddr = {pv_i_reg, pv_j_reg};
                        mat_wdata = alu_a_new;
                    end
                end
                state_next = (state_reg == ST_PR_FA) ? ST_PR_FB : ST_PR_B;
            end

            ST_PR_B:
            begin
                mat_raddr = {j_reg, i_reg};
                a_next    = mat_rdata;
                if (pend_reg && (func_reg == FN_NORM))
                begin
                    mat_we    = 1'b1;
                    mat_waddr = {pv_j_reg, pv_i_reg};
                    mat_wdata = bnew_reg;
                end
                pv_i_next = i_reg;
                pv_j_next = j_reg;
                pend_next = 1'b1;
                if (pair_last)
                begin
                    state_next = ST_PR_FA;
                end
                else if (j_last)
                begin
                    i_next     = i_reg + IW'(1);
                    j_next     = i_reg + IW'(2);
                    state_next = ST_PR_A;
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_PR_A;
                end
            end

            ST_PR_FB:
            begin
                if (func_reg == FN_NORM)
                begin
                    mat_we    = 1'b1;
                    mat_waddr = {pv_j_reg, pv_i_reg};
                    mat_wdata = bnew_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                case (func_reg)
                    FN_NORM:
                    begin
                        res.result_value = opt_reg[CELL_W-1] ? opt_ext : (opt_ext - acc_reg);
                    end
                    FN_BOUNDS:
                    begin
                        res.upper_value = acc2_reg;
                    end
                    default:
                    begin
                    end
                endcase
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = done;

    a_f2_follows_f1 : assert property (@(posedge clk) disable iff (!rst_n)
        f2_reg |-> $past(f1_reg))
        else $error("matrix accumulate without a perm read one cycle earlier");

    a_done_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE))
        else $error("result dropped while output register full");

    a_pair_order : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PR_A || state_reg == ST_PR_B) |-> (j_reg > i_reg))
        else $error("pair indices out of order");

    a_write_only_norm : assert property (@(posedge clk) disable iff (!rst_n)
        (mat_we && state_reg != ST_IDLE && state_reg != ST_NM_DIAG) |-> (func_reg == FN_NORM))
        else $error("matrix write outside load or normalize");

endmodule
`default_nettype wire

// File: rtl/linear_ordering_evaluator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_ordering_evaluator_top
// Linear ordering problem engine: weight matrix, permutation, objective.
// ----------------------------------------------------------------------------
// The matrix store has one read port, so commands are bound by it: evaluate
// reads one cell per cycle within a row, with a perm read per row; normalize
// clears the diagonal, then makes two reads per pair with write-back
// overlapped; bounds also makes two reads per pair. The input stalls while a
// command runs. No clearing pass: stores hold junk until loaded.
module linear_ordering_evaluator_top #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire lop_pkg::in_item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output lop_pkg::out_item_t                out_item,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lop_pkg::SIZE_W-1:0]   cfg_wr_data
);
    import lop_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [SIZE_W-1:0] size_reg;
    logic [CW-1:0]     n_use;
    logic              in_accept;
    logic              out_free;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    core_stat_t        stat;
    out_item_t         res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (32'(size_reg) > 32'(MAX_ITEMS))
        begin
            n_use = CW'(MAX_ITEMS);
        end
        else
        begin
            n_use = CW'(size_reg);
        end
    end

    assign in_stall  = stat.busy;
    assign in_accept = in_valid && !stat.busy;
    assign out_free  = !out_valid_reg || !out_stall;

    lop_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_item   (in_item),
        .n_use     (n_use),
        .out_free  (out_free),
        .stat      (stat),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire
